### hdl/lgnc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and neighbor offset tables for the grid census block
// no dependencies

package lgnc_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // grid size registers are seven bits wide
    localparam int SIZE_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EDGES  = 2'd2;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;
    localparam logic              WRAP_RESET = 1'b0;

    localparam logic [1:0] MODE_SET_LIVE = 2'd0;
    localparam logic [1:0] MODE_SET_DEAD = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;
    localparam logic [1:0] MODE_CENSUS   = 2'd3;

    // offset codes for one neighbor axis
    localparam logic [1:0] STEP_DEC  = 2'd0;
    localparam logic [1:0] STEP_HOLD = 2'd1;
    localparam logic [1:0] STEP_INC  = 2'd2;

    localparam logic [2:0] NB_LAST = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] row_index;
        logic [5:0] col_index;
    } in_item_t;

    typedef struct packed {
        logic       cell_alive;
        logic [3:0] neighbor_count;
        logic       out_of_range;
    } out_item_t;

    typedef struct packed {
        logic       mem_clear;
        logic       load_item;
        logic       cell_write;
        logic       write_val;
        logic       cell_read;
        logic       nb_read;
        logic [2:0] nb_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       oor;
        logic       clr_last;
        logic       out_free;
    } dp_status_t;

    // eight moore neighbors, center skipped
    function automatic logic [1:0] nb_row_step(input logic [2:0] k);
        logic [1:0] s;
        case (k)
            3'd0, 3'd1, 3'd2: s = STEP_DEC;
            3'd3, 3'd4:       s = STEP_HOLD;
            default:          s = STEP_INC;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] nb_col_step(input logic [2:0] k);
        logic [1:0] s;
        case (k)
            3'd0, 3'd3, 3'd5: s = STEP_DEC;
            3'd1, 3'd6:       s = STEP_HOLD;
            default:          s = STEP_INC;
        endcase
        return s;
    endfunction

endpackage

### hdl/life_grid_neighbor_census.sv
`timescale 1ns / 1ps
// grid census top level: one item at a time, one transfer out per item
// a census makes eight reads through the single grid ram port, then gives its result
// a new item is taken only once the previous one is done and its result is in the output register
// reset: async active low; a clearing pass over all MAX_ROWS*MAX_COLS cells zeroes the grid,
// input stays stalled until it ends; config registers may be written during the pass

module life_grid_neighbor_census #(
    parameter int MAX_ROWS = lgnc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgnc_pkg::MAX_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lgnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgnc_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lgnc_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lgnc_pkg::out_item_t             out_data
);

    lgnc_pkg::dp_cmd_t    cmd;
    lgnc_pkg::dp_status_t status;

    lgnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lgnc_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hdl/lgnc_ram.sv
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies

module lgnc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lgnc_dpath.sv
`timescale 1ns / 1ps
// datapath: config registers, item register, neighbor address logic, grid ram,
// count accumulator and output register; uses lgnc_pkg and lgnc_ram

module lgnc_dpath #(
    parameter int MAX_ROWS = lgnc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgnc_pkg::MAX_COLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lgnc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgnc_pkg::SIZE_W-1:0]       cfg_wdata,
    input  lgnc_pkg::in_item_t                in_data,
    input  lgnc_pkg::dp_cmd_t                 cmd,
    output lgnc_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lgnc_pkg::out_item_t               out_data
);

    localparam int SW    = lgnc_pkg::SIZE_W;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = SW + $clog2(MAX_COLS + 1);

    logic [SW-1:0]        rows_cfg_reg;
    logic [SW-1:0]        cols_cfg_reg;
    logic                 wrap_reg;
    lgnc_pkg::in_item_t   item_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 nb_pend_reg;
    logic                 rd_pend_reg;
    logic                 alive_reg;
    logic [3:0]           count_reg;
    logic                 out_valid_reg;
    lgnc_pkg::out_item_t  out_reg;

    logic [SW-1:0]        rows_eff;
    logic [SW-1:0]        cols_eff;
    logic [SW-1:0]        r_ext;
    logic [SW-1:0]        c_ext;
    logic [SW-1:0]        r_dec;
    logic [SW-1:0]        r_inc;
    logic [SW-1:0]        c_dec;
    logic [SW-1:0]        c_inc;
    logic                 r_dec_ok;
    logic                 r_inc_ok;
    logic                 c_dec_ok;
    logic                 c_inc_ok;
    logic [SW-1:0]        nb_r;
    logic [SW-1:0]        nb_c;
    logic                 nb_r_ok;
    logic                 nb_c_ok;
    logic [SW-1:0]        acc_r;
    logic [SW-1:0]        acc_c;
    logic [PW-1:0]        addr_full;
    logic                 mem_en;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic                 mem_wdata;
    logic                 mem_rdata;
    logic                 alive_next;
    logic [3:0]           count_next;
    logic                 oor;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = SW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = SW'(MAX_ROWS);
        else
            rows_eff = rows_cfg_reg;

        if (cols_cfg_reg == '0)
            cols_eff = SW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = SW'(MAX_COLS);
        else
            cols_eff = cols_cfg_reg;
    end

    assign r_ext = SW'(item_reg.row_index);
    assign c_ext = SW'(item_reg.col_index);
    assign oor   = (r_ext >= rows_eff) || (c_ext >= cols_eff);

    // one step each way, wrapping to the far edge when the torus is on
    assign r_dec    = (r_ext == '0) ? rows_eff - SW'(1) : r_ext - SW'(1);
    assign r_inc    = (r_ext + SW'(1) == rows_eff) ? '0 : r_ext + SW'(1);
    assign c_dec    = (c_ext == '0) ? cols_eff - SW'(1) : c_ext - SW'(1);
    assign c_inc    = (c_ext + SW'(1) == cols_eff) ? '0 : c_ext + SW'(1);
    assign r_dec_ok = wrap_reg || (r_ext != '0);
    assign r_inc_ok = wrap_reg || (r_ext + SW'(1) != rows_eff);
    assign c_dec_ok = wrap_reg || (c_ext != '0);
    assign c_inc_ok = wrap_reg || (c_ext + SW'(1) != cols_eff);

    always_comb
    begin
        case (lgnc_pkg::nb_row_step(cmd.nb_sel))
            lgnc_pkg::STEP_DEC:
            begin
                nb_r    = r_dec;
                nb_r_ok = r_dec_ok;
            end
            lgnc_pkg::STEP_INC:
            begin
                nb_r    = r_inc;
                nb_r_ok = r_inc_ok;
            end
            default:
            begin
                nb_r    = r_ext;
                nb_r_ok = 1'b1;
            end
        endcase

        case (lgnc_pkg::nb_col_step(cmd.nb_sel))
            lgnc_pkg::STEP_DEC:
            begin
                nb_c    = c_dec;
                nb_c_ok = c_dec_ok;
            end
            lgnc_pkg::STEP_INC:
            begin
                nb_c    = c_inc;
                nb_c_ok = c_inc_ok;
            end
            default:
            begin
                nb_c    = c_ext;
                nb_c_ok = 1'b1;
            end
        endcase
    end

    assign acc_r     = cmd.nb_read ? nb_r : r_ext;
    assign acc_c     = cmd.nb_read ? nb_c : c_ext;
    assign addr_full = PW'(acc_r) * PW'(MAX_COLS) + PW'(acc_c);

    assign mem_en    = cmd.mem_clear | cmd.cell_write | cmd.cell_read | cmd.nb_read;
    assign mem_we    = cmd.mem_clear | cmd.cell_write;
    assign mem_addr  = cmd.mem_clear ? clr_addr_reg : AW'(addr_full);
    assign mem_wdata = cmd.mem_clear ? 1'b0 : cmd.write_val;

    lgnc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // read data lands in the cycle after the request
    assign count_next = count_reg + 4'(nb_pend_reg & mem_rdata);
    assign alive_next = rd_pend_reg ? mem_rdata : alive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= lgnc_pkg::ROWS_RESET;
            cols_cfg_reg  <= lgnc_pkg::COLS_RESET;
            wrap_reg      <= lgnc_pkg::WRAP_RESET;
            clr_addr_reg  <= '0;
            nb_pend_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lgnc_pkg::CFG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata;
                    lgnc_pkg::CFG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata;
                    lgnc_pkg::CFG_WRAP_EDGES:  wrap_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.mem_clear)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            nb_pend_reg <= cmd.nb_read & nb_r_ok & nb_c_ok;
            rd_pend_reg <= cmd.cell_read;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg  <= in_data;
            alive_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            alive_reg <= alive_next;
            count_reg <= count_next;
        end
        if (cmd.out_load)
        begin
            out_reg.cell_alive     <= alive_next;
            out_reg.neighbor_count <= count_next;
            out_reg.out_of_range   <= oor;
        end
    end

    assign status.mode     = item_reg.mode;
    assign status.oor      = oor;
    assign status.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/lgnc_ctrl.sv
`timescale 1ns / 1ps
// controller: clearing pass after reset, item sequencing, census read steps
// uses lgnc_pkg

module lgnc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lgnc_pkg::dp_status_t  status,
    output lgnc_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CENSUS = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] nb_reg;
    logic [2:0] nb_next;
    logic [2:0] done_state;

    // result goes out now if the output register is free, else it waits
    assign done_state = status.out_free ? S_IDLE : S_RESULT;

    always_comb
    begin
        cmd        = '0;
        cmd.nb_sel = nb_reg;
        state_next = state_reg;
        nb_next    = nb_reg;
        in_stall   = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_clear = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.oor)
                begin
                    cmd.out_load = status.out_free;
                    state_next   = done_state;
                end
                else
                begin
                    case (status.mode)
                        lgnc_pkg::MODE_SET_LIVE,
                        lgnc_pkg::MODE_SET_DEAD:
                        begin
                            cmd.cell_write = 1'b1;
                            cmd.write_val  = (status.mode == lgnc_pkg::MODE_SET_LIVE);
                            cmd.out_load   = status.out_free;
                            state_next     = done_state;
                        end
                        lgnc_pkg::MODE_READ:
                        begin
                            cmd.cell_read = 1'b1;
                            state_next    = S_FLUSH;
                        end
                        default:
                        begin
                            cmd.nb_read = 1'b1;
                            cmd.nb_sel  = '0;
                            nb_next     = 3'd1;
                            state_next  = S_CENSUS;
                        end
                    endcase
                end
            end
            S_CENSUS:
            begin
                cmd.nb_read = 1'b1;
                if (nb_reg == lgnc_pkg::NB_LAST)
                    state_next = S_FLUSH;
                else
                    nb_next = nb_reg + 3'd1;
            end
            S_FLUSH, S_RESULT:
            begin
                cmd.out_load = status.out_free;
                state_next   = done_state;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            nb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
        end
    end

endmodule

### verif/life_grid_neighbor_census_test.sv
`timescale 1ns / 1ps
// self-checking bench for the grid census block: directed corner cases, then random phases
// keeps its own shadow copy of the cell grid and grid registers; needs lgnc_pkg and the top level

module life_grid_neighbor_census_test;

    import lgnc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 130;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [1:0]      cfg_index = '0;
    logic [6:0]      cfg_wdata = '0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    in_item_t        in_data = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    out_item_t       out_data;

    // shadow of the block: grid contents and the three registers
    logic            shadow_grid [0:63][0:63];
    logic [6:0]      shadow_rows;
    logic [6:0]      shadow_cols;
    logic            shadow_wrap;

    out_item_t       pending_results [$];
    int unsigned     fault_count = 0;
    int unsigned     idle_cycles = 0;

    // receiver stall pattern state
    int unsigned     stall_style = 0;
    int unsigned     style_left = 0;
    int unsigned     hold_left = 0;
    logic            stall_next;

    life_grid_neighbor_census i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // size register value as the block uses it: zero acts as one, oversize saturates
    function automatic int grid_extent(input logic [6:0] v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic out_item_t apply_grid_op(input in_item_t op);
        out_item_t res;
        int rows;
        int cols;
        int r;
        int c;
        int dr;
        int dc;
        int nr;
        int nc;
        res = '0;
        rows = grid_extent(shadow_rows, MAX_ROWS_DEF);
        cols = grid_extent(shadow_cols, MAX_COLS_DEF);
        r = op.row_index;
        c = op.col_index;
        if (r >= rows || c >= cols)
        begin
            res.out_of_range = 1'b1;
        end
        else
        begin
            case (op.mode)
                MODE_SET_LIVE: shadow_grid[r][c] = 1'b1;
                MODE_SET_DEAD: shadow_grid[r][c] = 1'b0;
                MODE_READ:     res.cell_alive = shadow_grid[r][c];
                default:
                begin
                    for (dr = -1; dr <= 1; dr++)
                    begin
                        for (dc = -1; dc <= 1; dc++)
                        begin
                            if (dr != 0 || dc != 0)
                            begin
                                nr = r + dr;
                                nc = c + dc;
                                // on a torus narrower than three a cell may see itself
                                if (shadow_wrap)
                                begin
                                    nr = (r + rows + dr) % rows;
                                    nc = (c + cols + dc) % cols;
                                end
                                if (nr >= 0 && nr < rows && nc >= 0 && nc < cols)
                                    res.neighbor_count = res.neighbor_count
                                                         + shadow_grid[nr][nc];
                            end
                        end
                    end
                end
            endcase
        end
        return res;
    endfunction

    // call at a rising edge; returns at the edge where the transfer happens, valid left high
    task automatic send_cell_op(input logic [1:0] mode, input int row, input int col);
        in_item_t op;
        op.mode = mode;
        op.row_index = row[5:0];
        op.col_index = col[5:0];
        in_valid <= 1'b1;
        in_data <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_grid_op(op));
    endtask

    task automatic sender_gap(input int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_grid_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols, input logic wrap);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_index <= CFG_COLS_IN_USE;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_index <= CFG_WRAP_EDGES;
        cfg_wdata <= {6'd0, wrap};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_rows = rows;
        shadow_cols = cols;
        shadow_wrap = wrap;
    endtask

    task automatic test_corner_cells();
        send_cell_op(MODE_SET_LIVE, 0, 0);
        send_cell_op(MODE_SET_LIVE, 0, 63);
        send_cell_op(MODE_SET_LIVE, 63, 0);
        send_cell_op(MODE_SET_LIVE, 63, 63);
        send_cell_op(MODE_SET_LIVE, 0, 1);
        send_cell_op(MODE_SET_LIVE, 1, 0);
        send_cell_op(MODE_SET_LIVE, 1, 1);
        send_cell_op(MODE_CENSUS, 0, 0);
        send_cell_op(MODE_CENSUS, 63, 63);
        send_cell_op(MODE_CENSUS, 1, 1);
        send_cell_op(MODE_READ, 63, 63);
        send_cell_op(MODE_SET_DEAD, 63, 63);
        send_cell_op(MODE_READ, 63, 63);
        wait_grid_idle();
    endtask

    task automatic test_torus_wrap();
        set_grid(7'd64, 7'd64, 1'b1);
        send_cell_op(MODE_SET_LIVE, 63, 63);
        send_cell_op(MODE_CENSUS, 0, 0);
        wait_grid_idle();
    endtask

    task automatic test_size_clamp();
        // zero rows acts as one row, 127 columns acts as the full width
        set_grid(7'd0, 7'd127, 1'b0);
        send_cell_op(MODE_READ, 0, 63);
        send_cell_op(MODE_SET_LIVE, 1, 0);
        send_cell_op(MODE_CENSUS, 0, 1);
        wait_grid_idle();
    endtask

    task automatic test_small_torus();
        set_grid(7'd1, 7'd2, 1'b1);
        send_cell_op(MODE_CENSUS, 0, 0);
        send_cell_op(MODE_SET_DEAD, 0, 1);
        send_cell_op(MODE_CENSUS, 0, 0);
        wait_grid_idle();
    endtask

    task automatic test_shrunk_grid();
        set_grid(7'd10, 7'd10, 1'b0);
        send_cell_op(MODE_READ, 63, 0);
        send_cell_op(MODE_SET_DEAD, 63, 0);
        wait_grid_idle();
        set_grid(7'd64, 7'd64, 1'b0);
        send_cell_op(MODE_READ, 63, 0);
        wait_grid_idle();
    endtask

    task automatic test_random_phases();
        logic [6:0]  rows_cfg;
        logic [6:0]  cols_cfg;
        logic        wrap_cfg;
        int          rows;
        int          cols;
        int          focus_row;
        int          focus_col;
        int          row;
        int          col;
        int          pick;
        int unsigned burst_left;
        logic [1:0]  mode;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin rows_cfg = 7'd64; cols_cfg = 7'd64; wrap_cfg = 1'b0; end
                1: begin rows_cfg = 7'd64; cols_cfg = 7'd64; wrap_cfg = 1'b1; end
                2: begin rows_cfg = 7'd3; cols_cfg = 7'd3; wrap_cfg = 1'b1; end
                3: begin rows_cfg = 7'd1; cols_cfg = 7'd1; wrap_cfg = 1'b1; end
                4: begin rows_cfg = 7'd2; cols_cfg = 7'd7; wrap_cfg = 1'b1; end
                5: begin rows_cfg = 7'd0; cols_cfg = 7'd127; wrap_cfg = 1'b0; end
                6: begin rows_cfg = 7'd127; cols_cfg = 7'd0; wrap_cfg = 1'b1; end
                default:
                begin
                    rows_cfg = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 12));
                    cols_cfg = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 12));
                    wrap_cfg = 1'($urandom_range(0, 1));
                end
            endcase
            set_grid(rows_cfg, cols_cfg, wrap_cfg);
            rows = grid_extent(rows_cfg, MAX_ROWS_DEF);
            cols = grid_extent(cols_cfg, MAX_COLS_DEF);
            focus_row = $urandom_range(0, rows - 1);
            focus_col = $urandom_range(0, cols - 1);
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    mode = MODE_SET_LIVE;
                else if (pick < 50)
                    mode = MODE_SET_DEAD;
                else if (pick < 70)
                    mode = MODE_READ;
                else
                    mode = MODE_CENSUS;
                // often a small patch so censuses meet live cells, else anywhere in the grid or beyond
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    row = $urandom_range(0, 63);
                    col = $urandom_range(0, 63);
                end
                else if (pick < 6)
                begin
                    row = (focus_row + $urandom_range(0, 4)) % rows;
                    col = (focus_col + $urandom_range(0, 4)) % cols;
                end
                else
                begin
                    row = $urandom_range(0, rows - 1);
                    col = $urandom_range(0, cols - 1);
                end
                send_cell_op(mode, row, col);
                burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 19) == 0)
                        wait_grid_idle();
                    else if ($urandom_range(0, 3) != 0)
                        sender_gap($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 24);
                end
            end
            wait_grid_idle();
        end
    endtask

    // receiver: the stall style is picked anew whenever its countdown runs out
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(50, 400);
        end
        else
        begin
            style_left--;
        end
        if (hold_left != 0)
        begin
            hold_left--;
        end
        else
        begin
            case (stall_style)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2:
                begin
                    stall_next = !out_stall;
                    hold_left = stall_next ? $urandom_range(0, 19) : $urandom_range(0, 9);
                end
                default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result at %0t: alive %0d count %0d oor %0d",
                             $time, out_data.cell_alive, out_data.neighbor_count,
                             out_data.out_of_range);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.cell_alive !== want.cell_alive
                    || out_data.neighbor_count !== want.neighbor_count
                    || out_data.out_of_range !== want.out_of_range)
                begin
                    if (fault_count < 10)
                        $display({"mismatch at %0t: expected alive %0d count %0d oor %0d, ",
                                  "got alive %0d count %0d oor %0d"},
                                 $time, want.cell_alive, want.neighbor_count,
                                 want.out_of_range, out_data.cell_alive,
                                 out_data.neighbor_count, out_data.out_of_range);
                    fault_count++;
                end
            end
        end
    end

    // covers the clearing pass after reset as well as a hung handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 64; c++)
                shadow_grid[r][c] = 1'b0;
        shadow_rows = ROWS_RESET;
        shadow_cols = COLS_RESET;
        shadow_wrap = WRAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_cells();
        test_torus_wrap();
        test_size_clamp();
        test_small_torus();
        test_shrunk_grid();
        test_random_phases();
        wait_grid_idle();
        if (fault_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
